// File: hdl/line_raster_into_bitmap_top_macros.svh
// Assertion macros shared by the line rasteriser RTL.
`ifndef LINE_RASTER_INTO_BITMAP_TOP_MACROS_SVH
`define LINE_RASTER_INTO_BITMAP_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LRIB_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("lrib assertion failed");

// Next-cycle implication, disabled during reset.
`define LRIB_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("lrib assertion failed");

`endif

// File: hdl/lrib_pkg.sv
// Package with shared types, codes and helpers of the line rasteriser.
package lrib_pkg;

  localparam int MAX_AW = 17;

  localparam logic [1:0] KIND_MOVE = 2'd0;
  localparam logic [1:0] KIND_LINE = 2'd1;
  localparam logic [1:0] KIND_FILL = 2'd2;
  localparam logic [1:0] KIND_READ = 2'd3;

  typedef struct packed {
    logic              we;
    logic [MAX_AW-1:0] addr;
    logic [7:0]        wdata;
  } store_req_t;

  function automatic logic [7:0] pixel_mask(input logic [2:0] bit_pos);
    pixel_mask = 8'h80 >> bit_pos;
  endfunction

endpackage

// File: hdl/lrib_store.sv
// Frame store: single-port byte memory with registered read data.
module lrib_store import lrib_pkg::*; #(
  parameter int DEPTH = 9600
) (
  input  logic       clk,
  input  store_req_t req,
  output logic [7:0] rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr[AW-1:0]] <= req.wdata;
    end
    rdata <= mem[req.addr[AW-1:0]];
  end

endmodule

// File: hdl/line_raster_into_bitmap_top.sv
// Top level of the 1-bit-per-pixel line rasteriser over a byte frame store.
//
//   Channel  | Direction | Handshake            | Payload
//   ---------+-----------+----------------------+-----------------------------------------
//   request  | in        | in_valid / in_stall  | kind, x_coord, y_coord, xor_mode,
//            |           |                      | fill_value, read_address
//   result   | out       | out_valid / out_stall| read_data, was_read
//
// A move passes through S_DONE, and a read through S_RD and S_DONE. A line takes one store
// read and one store write per pixel along its major axis (through the single memory port),
// with up to 512 pixels in the line that a pen beyond the store allows. A fill writes one
// byte per cycle, BYTES_PER_ROW * ROWS bytes (9600 by default). After reset a clearing pass
// over the whole store zeroes it while in_stall is held high. A stalled result waits in the
// output register while the next request may already be taken.
`include "line_raster_into_bitmap_top_macros.svh"

module line_raster_into_bitmap_top import lrib_pkg::*; #(
  parameter int BYTES_PER_ROW = 40,
  parameter int ROWS = 240
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [8:0]  x_coord,
  input  logic [7:0]  y_coord,
  input  logic        xor_mode,
  input  logic [7:0]  fill_value,
  input  logic [13:0] read_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  read_data,
  output logic        was_read
);

  localparam int STORE_SIZE = BYTES_PER_ROW * ROWS;
  localparam int AW = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_FILL, S_LRD, S_LWR, S_RD, S_DONE
  } state_t;

  state_t      state;
  logic [8:0]  pen_x, tgt_x, px;
  logic [7:0]  pen_y, tgt_y, py;
  logic        xmaj, neg_x, neg_y, tog, rd_ok;
  logic [8:0]  amaj, amin, step, rem;
  logic [AW-1:0] cnt;
  logic [7:0]  fill_byte, res_data;
  logic        res_read;

  store_req_t  req;
  logic [7:0]  rdata;
  logic        accept;
  logic [9:0]  dx, dy;
  logic [8:0]  adx, ady;
  logic [MAX_AW-1:0] pix_addr;
  logic        in_range;
  logic [9:0]  sum;
  logic        carry;
  logic [8:0]  rem_next;

  lrib_store #(.DEPTH(STORE_SIZE)) u_store (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // Signed deltas from the pen to the target and their magnitudes.
  assign dx  = {1'b0, x_coord} - {1'b0, pen_x};
  assign dy  = {2'b00, y_coord} - {2'b00, pen_y};
  assign adx = dx[9] ? 9'(-dx) : dx[8:0];
  assign ady = dy[9] ? 9'(-dy) : dy[8:0];

  // Byte address of the current pixel and its clipping test.
  assign pix_addr = MAX_AW'(32'(py) * 32'(BYTES_PER_ROW) + 32'(px[8:3]));
  assign in_range = (32'(px) < 32'(8 * BYTES_PER_ROW)) && (32'(py) < 32'(ROWS));

  // The shared add and compare unit: running remainder of amin * step / amaj.
  // The minor coordinate advances by one whenever the remainder wraps.
  assign sum      = {1'b0, rem} + {1'b0, amin};
  assign carry    = (sum >= {1'b0, amaj});
  assign rem_next = carry ? 9'(sum - {1'b0, amaj}) : sum[8:0];

  always_comb begin
    req.we    = 1'b0;
    req.addr  = MAX_AW'(read_address);
    req.wdata = fill_byte;
    case (state)
      S_CLEAR, S_FILL: begin
        req.we   = 1'b1;
        req.addr = MAX_AW'(cnt);
      end
      S_LRD: begin
        req.addr = pix_addr;
      end
      S_LWR: begin
        req.we    = in_range;
        req.addr  = pix_addr;
        req.wdata = tog ? (rdata ^ pixel_mask(px[2:0])) : (rdata | pixel_mask(px[2:0]));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cnt       <= '0;
      fill_byte <= '0;
      pen_x     <= '0;
      pen_y     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR, S_FILL: begin
          cnt <= cnt + 1'b1;
          if (cnt == AW'(STORE_SIZE - 1)) begin
            cnt <= '0;
            if (state == S_FILL) begin
              res_data <= '0;
              res_read <= 1'b0;
              state    <= S_DONE;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_IDLE: begin
          if (accept) begin
            res_data <= '0;
            res_read <= 1'b0;
            case (kind)
              KIND_MOVE: begin
                pen_x <= x_coord;
                pen_y <= y_coord;
                state <= S_DONE;
              end
              KIND_LINE: begin
                tgt_x <= x_coord;
                tgt_y <= y_coord;
                px    <= pen_x;
                py    <= pen_y;
                neg_x <= dx[9];
                neg_y <= dy[9];
                tog   <= xor_mode;
                xmaj  <= (ady < adx);
                amaj  <= (ady < adx) ? adx : ady;
                amin  <= (ady < adx) ? ady : adx;
                step  <= '0;
                rem   <= '0;
                state <= S_LRD;
              end
              KIND_FILL: begin
                fill_byte <= fill_value;
                cnt       <= '0;
                state     <= S_FILL;
              end
              KIND_READ: begin
                rd_ok <= (32'(read_address) < 32'(STORE_SIZE));
                state <= S_RD;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_LRD: begin
          state <= S_LWR;
        end
        S_LWR: begin
          if (step == amaj) begin
            pen_x <= tgt_x;
            pen_y <= tgt_y;
            state <= S_DONE;
          end else begin
            step <= step + 1'b1;
            rem  <= rem_next;
            if (xmaj) begin
              px <= neg_x ? px - 1'b1 : px + 1'b1;
              if (carry) begin
                py <= neg_y ? py - 1'b1 : py + 1'b1;
              end
            end else begin
              py <= neg_y ? py - 1'b1 : py + 1'b1;
              if (carry) begin
                px <= neg_x ? px - 1'b1 : px + 1'b1;
              end
            end
            state <= S_LRD;
          end
        end
        S_RD: begin
          res_data <= rd_ok ? rdata : 8'h00;
          res_read <= 1'b1;
          state    <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            read_data <= res_data;
            was_read  <= res_read;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A store write of a line always follows the read of the same byte.
  `LRIB_ASSERT_NOW(a_lwr_after_lrd, clk, rst, state == S_LWR, $past(state) == S_LRD)
  // The running remainder stays below the major length while a line is drawn.
  `LRIB_ASSERT_NOW(a_rem_bound, clk, rst, (state == S_LRD) && (amaj != 9'd0), rem < amaj)
  // An accepted request closes the input until its work is done.
  `LRIB_ASSERT_NEXT(a_busy_after_accept, clk, rst, accept, in_stall)

endmodule
